/* rtl/ace_pkg.sv */
`default_nettype none

package ace_pkg;

    // Default sizes of the section evaluator.
    localparam int SENSOR_SLOTS_DEF = 4;
    localparam int COUNT_BITS_DEF   = 15;

    // Width of the hold timer and of the hold_cycles register.
    localparam int HOLD_BITS = 8;
    localparam logic [HOLD_BITS-1:0] HOLD_RESET = 8'd30;

    // Configuration register indexes.
    localparam int ADDR_BITS = 2;
    typedef enum logic [ADDR_BITS-1:0] {
        REG_SENSOR_USED   = 2'd0,
        REG_ADD_DIRECTION = 2'd1,
        REG_HOLD_CYCLES   = 2'd2,
        REG_INITIAL_AXLES = 2'd3
    } ace_reg_idx_t;

    // Item kinds carried in tuser.
    typedef enum logic {
        MODE_CAPTURE  = 1'b0,
        MODE_EVALUATE = 1'b1
    } ace_mode_t;

    // Control of the lane stage as seen by the merging stage.
    typedef struct packed {
        logic      valid;
        ace_mode_t mode;
    } ace_ctl_t;

endpackage

`default_nettype wire

/* rtl/ace_lane.sv */
`default_nettype none

// One sensor lane: registers the signed contribution of its sensor slot
// to the section sum, and whether a used sensor reports a wheel.
module ace_lane #(
    parameter int COUNT_BITS = ace_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  load,
    input  wire logic [COUNT_BITS-1:0] count,
    input  wire logic                  used,
    input  wire logic                  add_dir,
    input  wire logic                  occ_in,
    output logic      [COUNT_BITS-1:0] term_reg,
    output logic                       occ_reg
);

    logic [COUNT_BITS-1:0] term_next;
    logic                  occ_next;

    always_comb begin
        if (!used) begin
            term_next = '0;
        end else if (add_dir) begin
            term_next = count;
        end else begin
            term_next = '0 - count;
        end
        occ_next = used & occ_in;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            term_reg <= term_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ace_merge.sv */
`default_nettype none

// Merging stage: adds the lane terms, updates the baseline and, for evaluate items, the axle
// total, free flag and hold timer, and holds the result in the output register.
module ace_merge #(
    parameter int SENSOR_SLOTS = ace_pkg::SENSOR_SLOTS_DEF,
    parameter int COUNT_BITS   = ace_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ace_pkg::ace_ctl_t                      ctl,
    input  wire logic [SENSOR_SLOTS-1:0][COUNT_BITS-1:0] terms,
    input  wire logic [SENSOR_SLOTS-1:0]                occ,
    input  wire logic [ace_pkg::HOLD_BITS-1:0]          hold_cycles,
    input  wire logic                                   init_wr,
    input  wire logic [COUNT_BITS-1:0]                  init_value,
    input  wire logic                                   m_ready,
    output logic                                        st_ready,
    output logic                                        m_valid_reg,
    output logic      [COUNT_BITS-1:0]                  m_count_reg,
    output logic                                        m_free_reg,
    output logic                                        m_pend_reg
);

    logic [COUNT_BITS-1:0]         base_reg;
    logic [COUNT_BITS-1:0]         total_reg;
    logic                          free_reg;
    logic [ace_pkg::HOLD_BITS-1:0] timer_reg;

    logic [COUNT_BITS-1:0]         sum_c;
    logic [COUNT_BITS-1:0]         total_new;
    logic                          occ_any;
    logic [ace_pkg::HOLD_BITS-1:0] timer_occ;
    logic                          free_occ;
    logic [ace_pkg::HOLD_BITS-1:0] timer_chk;
    logic                          free_eval;
    logic [ace_pkg::HOLD_BITS-1:0] timer_eval;

    logic                          advance;
    logic                          m_valid_next;
    logic [COUNT_BITS-1:0]         total_next;
    logic                          free_next;

    assign st_ready     = !m_valid_reg || m_ready;
    assign advance      = ctl.valid && st_ready;
    assign m_valid_next = st_ready ? ctl.valid : m_valid_reg;
    assign occ_any      = |occ;

    always_comb begin
        sum_c = '0;
        for (int i = 0; i < SENSOR_SLOTS; i++) begin
            sum_c = sum_c + terms[i];
        end
        total_new = total_reg + sum_c - base_reg;
    end

    // An occupied sensor or a nonzero total restarts the hold; the section
    // goes free only once the timer has run out on an empty section.
    always_comb begin
        timer_occ = occ_any ? hold_cycles : timer_reg;
        free_occ  = occ_any ? 1'b0 : free_reg;
        if (total_new != '0) begin
            timer_chk = hold_cycles;
            free_eval = 1'b0;
        end else begin
            timer_chk = timer_occ;
            free_eval = (timer_occ == '0) ? 1'b1 : free_occ;
        end
        timer_eval = (timer_chk != '0) ? timer_chk - 1'b1 : '0;
    end

    always_comb begin
        unique case (ctl.mode)
            ace_pkg::MODE_CAPTURE: begin
                total_next = total_reg;
                free_next  = free_reg;
            end
            ace_pkg::MODE_EVALUATE: begin
                total_next = total_new;
                free_next  = free_eval;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            base_reg    <= '0;
            total_reg   <= '0;
            free_reg    <= 1'b1;
            timer_reg   <= ace_pkg::HOLD_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (init_wr) begin
                total_reg <= init_value;
                free_reg  <= (init_value == '0);
            end else if (advance) begin
                base_reg <= sum_c;
                if (ctl.mode == ace_pkg::MODE_EVALUATE) begin
                    total_reg <= total_new;
                    free_reg  <= free_eval;
                    timer_reg <= timer_eval;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_count_reg <= total_next;
            m_free_reg  <= free_next;
            m_pend_reg  <= (total_next == '0) && !free_next;
        end
    end

`ifndef SYNTHESIS
    a_free_means_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        free_reg |-> (total_reg == '0)
    ) else $error("section free while axle total is nonzero");

    a_capture_keeps_total: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && ctl.mode == ace_pkg::MODE_CAPTURE && !init_wr)
            |=> (total_reg == $past(total_reg)) && (free_reg == $past(free_reg))
    ) else $error("capture transfer changed the axle total or free flag");

    a_stall_blocks_stage: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !advance
    ) else $error("lane stage advanced into a stalled output register");

    a_result_matches_state: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && !init_wr) |=> (m_count_reg == total_reg) && (m_free_reg == free_reg)
    ) else $error("result does not show the state after the transfer");
`endif

endmodule

`default_nettype wire

/* rtl/axle_counter_section_evaluator_unit.sv */
`default_nettype none

// Two register stages (lane, merge): an input is registered in the lane stage and its
// result then in the merging stage's output register, which holds it while stalled.
// Throughput: one item per cycle unless the output stalls; the state updates once per item.
// The lane stage can take one more item while a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears both stages, loads axle total 0, section free,
// baseline 0, hold timer 30, and the registers to used 0, direction 0, hold 30.
module axle_counter_section_evaluator_unit #(
    parameter int SENSOR_SLOTS = ace_pkg::SENSOR_SLOTS_DEF,
    parameter int COUNT_BITS   = ace_pkg::COUNT_BITS_DEF,
    localparam int S_DATA_W    = ((SENSOR_SLOTS * COUNT_BITS + SENSOR_SLOTS + 7) / 8) * 8,
    localparam int M_DATA_W    = ((COUNT_BITS + 2 + 7) / 8) * 8,
    localparam int CFG_W       = (COUNT_BITS > ace_pkg::HOLD_BITS) ? COUNT_BITS
                                                                   : ace_pkg::HOLD_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Input channel.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // sensor_count_0 .. sensor_count_N-1, then sensor_occupied_bits, zero padded
    input  wire logic [S_DATA_W-1:0]           s_axis_tdata,
    // mode
    input  wire logic                          s_axis_tuser,

    // Result channel.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // axle_count, section_free, clearing_pending, zero padded
    output logic      [M_DATA_W-1:0]           m_axis_tdata,

    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [ace_pkg::ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]              cfg_wdata
);

    // Configuration registers. The initial axle count is not kept: a write
    // loads it straight into the axle total in the merging stage.
    logic [SENSOR_SLOTS-1:0]       used_mask_reg;
    logic [SENSOR_SLOTS-1:0]       dir_mask_reg;
    logic [ace_pkg::HOLD_BITS-1:0] hold_reg;
    logic                          init_wr;

    always_comb begin
        init_wr = 1'b0;
        if (cfg_wr_en) begin
            unique case (ace_pkg::ace_reg_idx_t'(cfg_addr))
                ace_pkg::REG_SENSOR_USED:   init_wr = 1'b0;
                ace_pkg::REG_ADD_DIRECTION: init_wr = 1'b0;
                ace_pkg::REG_HOLD_CYCLES:   init_wr = 1'b0;
                ace_pkg::REG_INITIAL_AXLES: init_wr = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_mask_reg <= '0;
            dir_mask_reg  <= '0;
            hold_reg      <= ace_pkg::HOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (ace_pkg::ace_reg_idx_t'(cfg_addr))
                ace_pkg::REG_SENSOR_USED:   used_mask_reg <= cfg_wdata[SENSOR_SLOTS-1:0];
                ace_pkg::REG_ADD_DIRECTION: dir_mask_reg  <= cfg_wdata[SENSOR_SLOTS-1:0];
                ace_pkg::REG_HOLD_CYCLES:   hold_reg      <= cfg_wdata[ace_pkg::HOLD_BITS-1:0];
                ace_pkg::REG_INITIAL_AXLES: hold_reg      <= hold_reg;
            endcase
        end
    end

    // Lane stage control. The stage takes a new transfer whenever it is
    // empty or its current item moves on into the merging stage.
    logic st1_valid_reg;
    logic st1_valid_next;
    logic st1_mode_reg;
    logic st2_ready;
    logic st1_ready;
    logic s_load;

    assign st1_ready      = !st1_valid_reg || st2_ready;
    assign s_axis_tready  = st1_ready;
    assign s_load         = s_axis_tvalid && st1_ready;
    assign st1_valid_next = st1_ready ? s_axis_tvalid : st1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_load) begin
            st1_mode_reg <= s_axis_tuser;
        end
    end

    // One lane per sensor slot, each forming its signed contribution.
    logic [SENSOR_SLOTS-1:0][COUNT_BITS-1:0] lane_terms;
    logic [SENSOR_SLOTS-1:0]                 lane_occ;

    for (genvar g = 0; g < SENSOR_SLOTS; g++) begin : g_lane
        ace_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk     (aclk),
            .load     (s_load),
            .count    (s_axis_tdata[g*COUNT_BITS +: COUNT_BITS]),
            .used     (used_mask_reg[g]),
            .add_dir  (dir_mask_reg[g]),
            .occ_in   (s_axis_tdata[SENSOR_SLOTS*COUNT_BITS + g]),
            .term_reg (lane_terms[g]),
            .occ_reg  (lane_occ[g])
        );
    end

    ace_pkg::ace_ctl_t st1_ctl;
    assign st1_ctl.valid = st1_valid_reg;
    assign st1_ctl.mode  = ace_pkg::ace_mode_t'(st1_mode_reg);

    logic [COUNT_BITS-1:0] m_count;
    logic                  m_free;
    logic                  m_pend;

    ace_merge #(
        .SENSOR_SLOTS (SENSOR_SLOTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (st1_ctl),
        .terms       (lane_terms),
        .occ         (lane_occ),
        .hold_cycles (hold_reg),
        .init_wr     (init_wr),
        .init_value  (cfg_wdata[COUNT_BITS-1:0]),
        .m_ready     (m_axis_tready),
        .st_ready    (st2_ready),
        .m_valid_reg (m_axis_tvalid),
        .m_count_reg (m_count),
        .m_free_reg  (m_free),
        .m_pend_reg  (m_pend)
    );

    assign m_axis_tdata = {{(M_DATA_W - COUNT_BITS - 2){1'b0}}, m_pend, m_free, m_count};

endmodule

`default_nettype wire
